// ===== rtl/gcw_pkg.sv =====
// ----------------------------------------------------------------------------
// gcw_pkg
// Shared types, constants and helpers for the grid coverage walker.
// ----------------------------------------------------------------------------
package gcw_pkg;

  localparam int GRID_COLS  = 15;
  localparam int GRID_ROWS  = 15;
  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COORD_W    = 4;
  localparam int CELL_W     = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COORD_W:0]   coord_ext_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CELL_W-1:0]  cell_t;

  localparam cell_t CELL_FREE    = 2'd0;
  localparam cell_t CELL_BLOCKED = 2'd1;
  localparam cell_t CELL_VISITED = 2'd2;

  typedef enum logic {
    OP_MARK = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic {
    CFG_START_COL = 1'b0,
    CFG_START_ROW = 1'b1
  } cfg_idx_t;

  // Neighbour probe order
  typedef enum logic [1:0] {
    NB_DOWN = 2'd0,
    NB_FWD  = 2'd1,
    NB_UP   = 2'd2,
    NB_BACK = 2'd3
  } nb_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MARK  = 3'd1,
    ST_PROBE = 3'd2,
    ST_CHECK = 3'd3,
    ST_DONE  = 3'd4
  } state_t;

  typedef struct packed {
    logic load;
    logic mark;
    logic probe;
    logic enter;
    logic emit;
    nb_t  nb;
  } cmd_t;

  typedef struct packed {
    logic cand_off;
    logic cand_free;
  } sts_t;

  // Column-major cell address
  function automatic addr_t cell_addr(coord_t col, coord_t row);
    return addr_t'(col) * addr_t'(GRID_ROWS) + addr_t'(row);
  endfunction

endpackage

// ===== rtl/gcw_ram.sv =====
// ----------------------------------------------------------------------------
// gcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcw_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 225
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcw_ctrl
// Sequencer: accepts a transaction, marks a cell or walks the neighbour probes
// for a step, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  output logic          out_valid,
  input  logic          out_ready,
  output gcw_pkg::cmd_t cmd,
  input  gcw_pkg::sts_t sts
);

  gcw_pkg::state_t state_r, state_nxt;
  gcw_pkg::nb_t    nb_r, nb_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcw_pkg::ST_IDLE;
      nb_r        <= gcw_pkg::NB_DOWN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nb_r        <= nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    nb_nxt    = nb_r;
    cmd       = '0;
    cmd.nb    = nb_r;
    in_ready  = 1'b0;
    unique case (state_r)
      gcw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          nb_nxt    = gcw_pkg::NB_DOWN;
          state_nxt = (gcw_pkg::op_t'(in_op) == gcw_pkg::OP_STEP) ?
                      gcw_pkg::ST_PROBE : gcw_pkg::ST_MARK;
        end
      end
      gcw_pkg::ST_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = gcw_pkg::ST_DONE;
      end
      gcw_pkg::ST_PROBE: begin
        cmd.probe = 1'b1;
        if (!sts.cand_off) begin
          state_nxt = gcw_pkg::ST_CHECK;
        end else if (nb_r == gcw_pkg::NB_BACK) begin
          state_nxt = gcw_pkg::ST_DONE;
        end else begin
          nb_nxt = gcw_pkg::nb_t'(nb_r + 2'd1);
        end
      end
      gcw_pkg::ST_CHECK: begin
        if (sts.cand_free) begin
          cmd.enter = 1'b1;
          state_nxt = gcw_pkg::ST_DONE;
        end else if (nb_r == gcw_pkg::NB_BACK) begin
          state_nxt = gcw_pkg::ST_DONE;
        end else begin
          nb_nxt    = gcw_pkg::nb_t'(nb_r + 2'd1);
          state_nxt = gcw_pkg::ST_PROBE;
        end
      end
      gcw_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = gcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_enter_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enter |-> !sts.cand_off)
    else $error("walker entered a cell off the grid");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == gcw_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcw_pkg::ST_DONE && out_valid_r && !out_ready)
      |=> state_r == gcw_pkg::ST_DONE)
    else $error("done state left while the output register was full");
`endif

endmodule

// ===== rtl/gcw_dpath.sv =====
// ----------------------------------------------------------------------------
// gcw_dpath
// Walker position, heading, cell store with valid bits, neighbour address
// generation and the output register.
// ----------------------------------------------------------------------------
module gcw_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gcw_pkg::cmd_t          cmd,
  output gcw_pkg::sts_t          sts,
  input  logic                   in_op,
  input  gcw_pkg::coord_t        in_cell_col,
  input  gcw_pkg::coord_t        in_cell_row,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  gcw_pkg::coord_t        cfg_wdata,
  output gcw_pkg::coord_t        out_pos_col,
  output gcw_pkg::coord_t        out_pos_row,
  output logic                   out_moved,
  output logic                   out_heading
);

  gcw_pkg::op_t    op_r;
  gcw_pkg::coord_t cc_r, cr_r;
  gcw_pkg::coord_t col_r, col_nxt, row_r, row_nxt;
  logic            dir_r, dir_nxt;
  logic            moved_r;
  logic [gcw_pkg::CELL_COUNT-1:0] vld_r;
  logic            vld_rd_r;

  gcw_pkg::coord_ext_t cand_c, cand_r;
  gcw_pkg::addr_t      cand_addr, mark_addr, wr_addr;
  gcw_pkg::cell_t      wr_data, rd_data;
  logic                mark_in_grid, wr_en;
  gcw_pkg::coord_t     clamp_col, clamp_row;

  // Candidate neighbour; a step below zero wraps high and reads as off grid
  always_comb begin
    cand_c = {1'b0, col_r};
    cand_r = {1'b0, row_r};
    unique case (cmd.nb)
      gcw_pkg::NB_DOWN: cand_r = {1'b0, row_r} + gcw_pkg::coord_ext_t'(1);
      gcw_pkg::NB_FWD:  cand_c = dir_r ? {1'b0, col_r} - gcw_pkg::coord_ext_t'(1)
                                       : {1'b0, col_r} + gcw_pkg::coord_ext_t'(1);
      gcw_pkg::NB_UP:   cand_r = {1'b0, row_r} - gcw_pkg::coord_ext_t'(1);
      gcw_pkg::NB_BACK: cand_c = dir_r ? {1'b0, col_r} + gcw_pkg::coord_ext_t'(1)
                                       : {1'b0, col_r} - gcw_pkg::coord_ext_t'(1);
      default: ;
    endcase
  end

  assign sts.cand_off = (cand_c >= gcw_pkg::coord_ext_t'(gcw_pkg::GRID_COLS)) ||
                        (cand_r >= gcw_pkg::coord_ext_t'(gcw_pkg::GRID_ROWS));
  assign cand_addr    = gcw_pkg::cell_addr(cand_c[gcw_pkg::COORD_W-1:0],
                                           cand_r[gcw_pkg::COORD_W-1:0]);
  assign sts.cand_free = !vld_rd_r || (rd_data == gcw_pkg::CELL_FREE);

  assign mark_in_grid = (cc_r < gcw_pkg::coord_t'(gcw_pkg::GRID_COLS)) &&
                        (cr_r < gcw_pkg::coord_t'(gcw_pkg::GRID_ROWS));
  assign mark_addr    = gcw_pkg::cell_addr(cc_r, cr_r);

  assign wr_en   = (cmd.mark && mark_in_grid) || cmd.enter;
  assign wr_addr = cmd.enter ? cand_addr : mark_addr;
  assign wr_data = cmd.enter ? gcw_pkg::CELL_VISITED : gcw_pkg::CELL_BLOCKED;

  gcw_ram #(
    .WIDTH (gcw_pkg::CELL_W),
    .DEPTH (gcw_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.probe),
    .raddr (cand_addr),
    .rdata (rd_data)
  );

  assign clamp_col = (cfg_wdata > gcw_pkg::coord_t'(gcw_pkg::GRID_COLS - 1)) ?
                     gcw_pkg::coord_t'(gcw_pkg::GRID_COLS - 1) : cfg_wdata;
  assign clamp_row = (cfg_wdata > gcw_pkg::coord_t'(gcw_pkg::GRID_ROWS - 1)) ?
                     gcw_pkg::coord_t'(gcw_pkg::GRID_ROWS - 1) : cfg_wdata;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      unique case (gcw_pkg::cfg_idx_t'(cfg_index))
        gcw_pkg::CFG_START_COL: col_nxt = clamp_col;
        gcw_pkg::CFG_START_ROW: row_nxt = clamp_row;
        default: ;
      endcase
    end else if (cmd.enter) begin
      col_nxt = cand_c[gcw_pkg::COORD_W-1:0];
      row_nxt = cand_r[gcw_pkg::COORD_W-1:0];
    end
  end

  // Reverse the heading on reaching the far column of a sweep
  always_comb begin
    dir_nxt = dir_r;
    if (op_r == gcw_pkg::OP_STEP) begin
      if (!dir_r) begin
        dir_nxt = (col_r == gcw_pkg::coord_t'(gcw_pkg::GRID_COLS - 1));
      end else begin
        dir_nxt = (col_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      dir_r   <= 1'b0;
      vld_r   <= '0;
      moved_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cmd.emit) begin
        dir_r <= dir_nxt;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.load) begin
        moved_r <= 1'b0;
      end else if (cmd.enter) begin
        moved_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= gcw_pkg::op_t'(in_op);
      cc_r <= in_cell_col;
      cr_r <= in_cell_row;
    end
    if (cmd.probe) begin
      vld_rd_r <= sts.cand_off ? 1'b0 : vld_r[cand_addr];
    end
    if (cmd.emit) begin
      out_pos_col <= col_r;
      out_pos_row <= row_r;
      out_moved   <= moved_r;
      out_heading <= dir_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < gcw_pkg::coord_t'(gcw_pkg::GRID_COLS)) &&
    (row_r < gcw_pkg::coord_t'(gcw_pkg::GRID_ROWS)))
    else $error("walker position left the grid");

  a_enter_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enter |=> moved_r && vld_r[gcw_pkg::cell_addr(col_r, row_r)])
    else $error("entered cell not recorded as visited");
`endif

endmodule

// ===== rtl/grid_coverage_walker_top.sv =====
// ----------------------------------------------------------------------------
// grid_coverage_walker_top
// Coverage walker over a 15 x 15 grid of free, blocked and visited cells.
// ----------------------------------------------------------------------------
// One transaction in, one result out. A mark passes through the mark and done
// states before its result is raised. A step probes the neighbours in turn:
// each on-grid neighbour takes a probe state (address) and a check state
// (registered read of the single-read cell RAM), while an off-grid neighbour
// is skipped from the probe state alone. A result that has not been taken
// stalls the block only when the next result is ready to be placed. The next
// transaction is accepted once the previous result has been placed in the
// output register, even if it has not yet been taken. The cell store clears
// at reset through per-cell valid bits, so no clearing pass is needed.
// Configuration writes (start column, start row) move the walker at once,
// saturated to the grid, and should be issued only while the block is idle.
module grid_coverage_walker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [3:0] in_cell_col,
  input  logic [3:0] in_cell_row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_pos_col,
  output logic [3:0] out_pos_row,
  output logic       out_moved,
  output logic       out_heading,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata
);

  gcw_pkg::cmd_t cmd;
  gcw_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  gcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gcw_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_op),
    .in_cell_col (in_cell_col),
    .in_cell_row (in_cell_row),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_pos_col (out_pos_col),
    .out_pos_row (out_pos_row),
    .out_moved   (out_moved),
    .out_heading (out_heading)
  );

endmodule

// ===== verif/gcw_checker.sv =====
// ----------------------------------------------------------------------------
// gcw_checker
// Tracks the walker grid from observed mark, step and start-register
// transactions. Checks every result against the predicted position, move flag
// and heading, and counts mismatches and results that nothing asked for.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcw_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_op,
  input  logic [3:0] in_cell_col,
  input  logic [3:0] in_cell_row,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_pos_col,
  input  logic [3:0] out_pos_row,
  input  logic       out_moved,
  input  logic       out_heading,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  output int         fail_count,
  output int         pending,
  output int         results_seen,
  output int         moves_seen
);

  typedef struct packed {
    gcw_pkg::coord_t col;
    gcw_pkg::coord_t row;
    logic            moved;
    logic            heading;
  } walk_result_t;

  gcw_pkg::cell_t  cell_map [gcw_pkg::GRID_COLS][gcw_pkg::GRID_ROWS];
  gcw_pkg::coord_t walk_col;
  gcw_pkg::coord_t walk_row;
  logic            sweep_back;
  walk_result_t    expected_walk [$];
  int              fails = 0;
  int              results = 0;
  int              moves = 0;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    moves_seen   = 0;
  end

  // Enter the neighbour at the given offset if it is on the grid and free.
  function automatic logic enter_cell(int dc, int dr);
    int c;
    int r;
    c = int'(walk_col) + dc;
    r = int'(walk_row) + dr;
    if (c < 0 || r < 0 || c >= gcw_pkg::GRID_COLS || r >= gcw_pkg::GRID_ROWS)
      return 1'b0;
    if (cell_map[c][r] != gcw_pkg::CELL_FREE) return 1'b0;
    cell_map[c][r] = gcw_pkg::CELL_VISITED;
    walk_col = gcw_pkg::coord_t'(c);
    walk_row = gcw_pkg::coord_t'(r);
    return 1'b1;
  endfunction

  function automatic walk_result_t predict_walk(gcw_pkg::op_t op,
                                                gcw_pkg::coord_t col,
                                                gcw_pkg::coord_t row);
    walk_result_t res;
    int fwd;
    res.moved = 1'b0;
    if (op == gcw_pkg::OP_MARK) begin
      if (col < gcw_pkg::GRID_COLS && row < gcw_pkg::GRID_ROWS)
        cell_map[col][row] = gcw_pkg::CELL_BLOCKED;
    end else begin
      fwd = sweep_back ? -1 : 1;
      // probe order: down, forward, up, backward
      if (enter_cell(0, 1)) res.moved = 1'b1;
      else if (enter_cell(fwd, 0)) res.moved = 1'b1;
      else if (enter_cell(0, -1)) res.moved = 1'b1;
      else if (enter_cell(-fwd, 0)) res.moved = 1'b1;
      if (!sweep_back && walk_col == gcw_pkg::coord_t'(gcw_pkg::GRID_COLS - 1))
        sweep_back = 1'b1;
      else if (sweep_back && walk_col == '0)
        sweep_back = 1'b0;
    end
    res.col     = walk_col;
    res.row     = walk_row;
    res.heading = sweep_back;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    walk_result_t want;
    if (!rst_n) begin
      foreach (cell_map[c, r]) cell_map[c][r] = gcw_pkg::CELL_FREE;
      walk_col   = '0;
      walk_row   = '0;
      sweep_back = 1'b0;
      expected_walk.delete();
    end else begin
      // a start write moves the walker at once, saturated to the grid
      if (cfg_valid && cfg_ready) begin
        case (gcw_pkg::cfg_idx_t'(cfg_index))
          gcw_pkg::CFG_START_COL: begin
            walk_col = (cfg_wdata > gcw_pkg::coord_t'(gcw_pkg::GRID_COLS - 1)) ?
                       gcw_pkg::coord_t'(gcw_pkg::GRID_COLS - 1) : cfg_wdata;
          end
          gcw_pkg::CFG_START_ROW: begin
            walk_row = (cfg_wdata > gcw_pkg::coord_t'(gcw_pkg::GRID_ROWS - 1)) ?
                       gcw_pkg::coord_t'(gcw_pkg::GRID_ROWS - 1) : cfg_wdata;
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results++;
        if (expected_walk.size() == 0) begin
          fails++;
          $error("result with no transaction pending: pos_col %0d pos_row %0d",
                 out_pos_col, out_pos_row);
        end else begin
          want = expected_walk.pop_front();
          if (want.moved) moves++;
          if (out_pos_col !== want.col) begin
            fails++;
            $error("pos_col: expected %0d, got %0d", want.col, out_pos_col);
          end
          if (out_pos_row !== want.row) begin
            fails++;
            $error("pos_row: expected %0d, got %0d", want.row, out_pos_row);
          end
          if (out_moved !== want.moved) begin
            fails++;
            $error("moved: expected %0d, got %0d", want.moved, out_moved);
          end
          if (out_heading !== want.heading) begin
            fails++;
            $error("heading: expected %0d, got %0d", want.heading, out_heading);
          end
        end
      end
      if (in_valid && in_ready)
        expected_walk.insert(expected_walk.size(),
                             predict_walk(gcw_pkg::op_t'(in_op), in_cell_col,
                                          in_cell_row));
    end
    fail_count   <= fails;
    pending      <= expected_walk.size();
    results_seen <= results;
    moves_seen   <= moves;
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the grid coverage walker with directed and random mark and step
// transactions across several start positions, with bursty input and a
// stalling result side. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int PHASES     = 10;
  localparam int PHASE_ITEMS = 48;
  localparam int SETTLE     = 12;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_op = 1'b0;
  logic [3:0] in_cell_col = '0;
  logic [3:0] in_cell_row = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_pos_col;
  logic [3:0] out_pos_row;
  logic       out_moved;
  logic       out_heading;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [3:0] cfg_wdata = '0;

  int          fail_count;
  int          pending;
  int          results_seen;
  int          moves_seen;
  int          items_sent = 0;
  int          writes_done = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned stall_tick = 0;

  grid_coverage_walker_top dut (.*);

  gcw_checker walk_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: steady, random and periodic stretches in turn
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick / 200) % 3)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(2, 0) != 0);
      default: out_ready <= ((stall_tick % 5) < 2);
    endcase
  end

  task automatic send_item(input gcw_pkg::op_t op, input logic [3:0] col,
                           input logic [3:0] row);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(7, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(12, 1);
    end
    if (burst_left > 0) burst_left--;
    in_valid    <= 1'b1;
    in_op       <= op;
    in_cell_col <= col;
    in_cell_row <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // hold valid across back-to-back writes, drop it after the last
  task automatic write_reg(input gcw_pkg::cfg_idx_t idx, input logic [3:0] value,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
    writes_done++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [3:0] col;
    logic [3:0] row;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // start at the origin: off-grid marks, return to the unvisited start cell,
    // block the walker's own cell
    send_item(gcw_pkg::OP_MARK, 4'd15, 4'd0);
    send_item(gcw_pkg::OP_MARK, 4'd0, 4'd15);
    send_item(gcw_pkg::OP_MARK, 4'd15, 4'd15);
    send_item(gcw_pkg::OP_STEP, 4'd0, 4'd0);
    send_item(gcw_pkg::OP_MARK, 4'd0, 4'd2);
    send_item(gcw_pkg::OP_MARK, 4'd1, 4'd1);
    send_item(gcw_pkg::OP_STEP, 4'd15, 4'd15);
    send_item(gcw_pkg::OP_STEP, 4'd0, 4'd0);
    send_item(gcw_pkg::OP_MARK, 4'd1, 4'd0);
    send_item(gcw_pkg::OP_STEP, 4'd0, 4'd0);

    // far column: heading reverses, then a dead end against the grid edge
    wait_idle();
    write_reg(gcw_pkg::CFG_START_COL, 4'd14, 1'b0);
    write_reg(gcw_pkg::CFG_START_ROW, 4'd0, 1'b1);
    send_item(gcw_pkg::OP_STEP, 4'd0, 4'd0);
    send_item(gcw_pkg::OP_MARK, 4'd14, 4'd2);
    send_item(gcw_pkg::OP_MARK, 4'd13, 4'd1);
    send_item(gcw_pkg::OP_MARK, 4'd14, 4'd0);
    send_item(gcw_pkg::OP_STEP, 4'd0, 4'd0);

    // saturated start on the far corner, blocked under the walker
    wait_idle();
    write_reg(gcw_pkg::CFG_START_COL, 4'd15, 1'b0);
    write_reg(gcw_pkg::CFG_START_ROW, 4'd15, 1'b1);
    send_item(gcw_pkg::OP_MARK, 4'd14, 4'd14);
    repeat (6) send_item(gcw_pkg::OP_STEP, 4'd0, 4'd0);

    // near column while sweeping back: heading turns forward again
    wait_idle();
    write_reg(gcw_pkg::CFG_START_COL, 4'd0, 1'b0);
    write_reg(gcw_pkg::CFG_START_ROW, 4'd14, 1'b1);
    send_item(gcw_pkg::OP_STEP, 4'd15, 4'd15);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       begin col = 4'd0;  row = 4'd0;  end
        1:       begin col = 4'd15; row = 4'd15; end
        2:       begin col = 4'd14; row = 4'd0;  end
        3:       begin col = 4'd0;  row = 4'd14; end
        default: begin
          col = 4'($urandom_range(15, 0));
          row = 4'($urandom_range(15, 0));
        end
      endcase
      if ($urandom_range(1, 0) != 0) begin
        write_reg(gcw_pkg::CFG_START_COL, col, 1'b0);
        write_reg(gcw_pkg::CFG_START_ROW, row, 1'b1);
      end else begin
        write_reg(gcw_pkg::CFG_START_ROW, row, 1'b0);
        write_reg(gcw_pkg::CFG_START_COL, col, 1'b1);
      end
      gaps_on = (ph % 3 != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(($urandom_range(3, 0) == 0) ? gcw_pkg::OP_MARK : gcw_pkg::OP_STEP,
                  4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)));
      end
    end

    wait_idle();
    $display("walker run: %0d transactions, %0d results checked, %0d moves",
             items_sent, results_seen, moves_seen);
    $display("%0d register writes; covered off-grid marks, blocked walker cells,",
             writes_done);
    $display("dead ends and starts on all edges");
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== grid_coverage_walker_top.f =====
rtl/gcw_pkg.sv
rtl/gcw_ram.sv
rtl/gcw_ctrl.sv
rtl/gcw_dpath.sv
rtl/grid_coverage_walker_top.sv
verif/gcw_checker.sv
verif/testbench.sv
